FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: payload words,
// operation and error codes, and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default number of cells
  localparam int unsigned SPQ_DEPTH = 16;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned FILL_W = 5;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_POP    = 2'd1,
    FN_CHANGE = 2'd2,
    FN_CLEAR  = 2'd3
  } spq_func_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_EMPTY     = 2'd1,
    ERR_FULL      = 2'd2,
    ERR_NOT_FOUND = 2'd3
  } spq_err_e;

  // per-cycle command seen by all cells
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_INS  = 3'd1,
    CELL_POP  = 3'd2,
    CELL_DEL  = 3'd3,
    CELL_CLR  = 3'd4
  } cell_op_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   ent;
  } cell_ctrl_t;

  typedef struct packed {
    spq_func_e         func;
    logic [ID_W-1:0]   patient_id;
    logic [PRIO_W-1:0] prio;
  } spq_in_t;

  typedef struct packed {
    logic [ID_W-1:0]   popped_id;
    logic [ID_W-1:0]   head_id;
    logic [PRIO_W-1:0] head_prio;
    logic              is_empty;
    logic [FILL_W-1:0] fill_count;
    spq_err_e          err_code;
  } spq_out_t;

endpackage

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Holds an entry and a valid bit, compares
// against the broadcast word and takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                left_keep_i,
  input  spq_pkg::entry_t     left_ent_i,
  input  logic                left_vld_i,
  input  spq_pkg::entry_t     right_ent_i,
  input  logic                right_vld_i,
  input  logic                del_i,
  output logic                keep_o,
  output logic                match_o,
  output spq_pkg::entry_t     ent_o,
  output logic                vld_o
);
  import spq_pkg::*;

  entry_t ent_q, ent_d;
  logic   vld_q, vld_d;

  // entry stays put on insert when its priority is not above the new one
  assign keep_o  = vld_q && (ent_q.prio <= ctrl_i.ent.prio);
  assign match_o = vld_q && (ent_q.id == ctrl_i.ent.id);

  always_comb begin
    ent_d = ent_q;
    vld_d = vld_q;
    case (ctrl_i.op)
      CELL_INS: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            ent_d = ctrl_i.ent;
            vld_d = 1'b1;
          end else begin
            ent_d = left_ent_i;
            vld_d = left_vld_i;
          end
        end
      end
      CELL_POP: begin
        ent_d = right_ent_i;
        vld_d = right_vld_i;
      end
      CELL_DEL: begin
        if (del_i) begin
          ent_d = right_ent_i;
          vld_d = right_vld_i;
        end
      end
      CELL_CLR: vld_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
  assign vld_o = vld_q;

endmodule

FILE: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept as a chain of sorted cells, smallest first.
// ----------------------------------------------------------------------------
// usage
//   in channel  : in_valid_i / in_ready_o carry one command word (func,
//                 patient_id, prio); out channel: out_valid_o / out_ready_i
//                 carry one result word per command
//   every cell compares against the command in parallel, so insert, pop,
//   clear and removal each update the whole cell chain together
//   sequence    : insert, pop, clear and failed commands go from idle to the
//                 response step, which loads the output register; a change
//                 of priority removes the entry first and re-inserts it in
//                 its own step before the response step
//   the command sequencer owns the chain and takes a new command only when idle
//   equal priorities leave in arrival order: a new entry goes behind all
//   entries of equal priority
//   reset       : all cells invalid, queue empty, no result pending
//   stall       : a result waits in the output register until taken; the
//                 sequencer holds the next result and accepts no new word
//                 until the previous one has been loaded
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  spq_pkg::spq_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_REINS = 3'b010,
    ST_RESP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;

  // pending result fields and the entry waiting for re-insert
  logic [ID_W-1:0] popped_q, popped_d;
  spq_err_e        err_q, err_d;
  entry_t          pend_q, pend_d;

  // output register
  logic     out_valid_q, out_valid_d;
  spq_out_t out_q, out_d;

  // cell chain wiring
  cell_ctrl_t       ctrl;
  entry_t           ent   [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] keep;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] left_keep;
  logic [DEPTH-1:0] below;
  logic [DEPTH-1:0] del_vec;
  logic             found;

  logic accept;
  logic full, empty;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);

  // first cell always sees a keeping left neighbor
  assign left_keep = {keep[DEPTH-2:0], 1'b1};

  // cells at or behind the first match shift left on removal
  assign found   = |match;
  assign below   = (match - DEPTH'(1)) & ~match;
  assign del_vec = ~below;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t l_ent, r_ent;
    logic   l_vld, r_vld;

    if (i == 0) begin : g_first
      assign l_ent = '0;
      assign l_vld = 1'b0;
    end else begin : g_left
      assign l_ent = ent[i-1];
      assign l_vld = vld[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_ent = '0;
      assign r_vld = 1'b0;
    end else begin : g_right
      assign r_ent = ent[i+1];
      assign r_vld = vld[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_keep_i (left_keep[i]),
      .left_ent_i  (l_ent),
      .left_vld_i  (l_vld),
      .right_ent_i (r_ent),
      .right_vld_i (r_vld),
      .del_i       (del_vec[i]),
      .keep_o      (keep[i]),
      .match_o     (match[i]),
      .ent_o       (ent[i]),
      .vld_o       (vld[i])
    );
  end

  // command sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    popped_d    = popped_q;
    err_d       = err_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ctrl.op       = CELL_HOLD;
    ctrl.ent.id   = in_data_i.patient_id;
    ctrl.ent.prio = in_data_i.prio;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          popped_d = '0;
          err_d    = ERR_OK;
          state_d  = ST_RESP;
          case (in_data_i.func)
            FN_INSERT: begin
              if (full) begin
                err_d = ERR_FULL;
              end else begin
                ctrl.op = CELL_INS;
                count_d = count_q + CW'(1);
              end
            end
            FN_POP: begin
              if (empty) begin
                err_d = ERR_EMPTY;
              end else begin
                ctrl.op  = CELL_POP;
                popped_d = ent[0].id;
                count_d  = count_q - CW'(1);
              end
            end
            FN_CHANGE: begin
              if (!found) begin
                err_d = ERR_NOT_FOUND;
              end else begin
                ctrl.op     = CELL_DEL;
                count_d     = count_q - CW'(1);
                pend_d.id   = in_data_i.patient_id;
                pend_d.prio = in_data_i.prio;
                state_d     = ST_REINS;
              end
            end
            FN_CLEAR: begin
              ctrl.op = CELL_CLR;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_REINS: begin
        ctrl.op  = CELL_INS;
        ctrl.ent = pend_q;
        count_d  = count_q + CW'(1);
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        // load the result once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.popped_id    = popped_q;
          out_d.head_id      = empty ? '0 : ent[0].id;
          out_d.head_prio    = empty ? '0 : ent[0].prio;
          out_d.is_empty     = empty;
          out_d.fill_count   = FILL_W'(count_q);
          out_d.err_code     = err_q;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    err_q    <= err_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // the count never runs past the chain length
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // valid cells always match the count
  a_count_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld) == int'(count_q))
    else $error("valid cells disagree with count");

  // re-insert only directly after a removal
  a_reins_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REINS) |-> $past(state_q == ST_IDLE))
    else $error("re-insert without removal");

  // a new result appears only out of the response step
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result loaded outside response step");
`endif

endmodule
